/* design/srb_pkg.sv */
// Shared constants and tables for the stakeout range and bearing pipeline.
`default_nettype none

package srb_pkg;

   // Defaults for the top-level parameters
   localparam int CORDIC_STAGES_DEF = 24;
   localparam int COORD_BITS_DEF    = 40;

   // Datapath widths
   localparam int CORDIC_W   = 64;  // x and y of the rotator
   localparam int SCALE_BITS = 61;  // |delta| is scaled to 2^SCALE_BITS full range
   localparam int ANGLE_W    = 32;  // binary angle, 2^32 is one turn
   localparam int BEARING_W  = 25;
   localparam int TOL_W      = 32;
   localparam int ATAN_LEN   = 40;

   // 1/K of the CORDIC gain in Q32, and one turn in 1/65536 degree
   localparam logic [TOL_W-1:0]     INV_GAIN   = 32'd2608131496;
   localparam logic [BEARING_W-1:0] TURN_UNITS = 25'd23592960;

   // Sideband flag positions; the three deltas follow from SIDE_DN upward
   localparam int SIDE_TSET    = 0;
   localparam int SIDE_ZERO    = 1;
   localparam int SIDE_REACHED = 2;
   localparam int SIDE_DN      = 3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_NORTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_EAST     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ELEV     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REACH_TOLERANCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SET      = 3'd4;

   // atan(2^-i) as a binary angle, rounded to nearest
   localparam logic [ANGLE_W-1:0] ATAN_BAM [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
      32'd0,         32'd0,         32'd0,         32'd0,        32'd0
   };

endpackage

`default_nettype wire

/* design/srb_front.sv */
// Front stages: deltas, absolute offsets, exact reach test and rotator seed.
`default_nettype none

module srb_front
   import srb_pkg::*;
#(
   parameter  int COORD_BITS = COORD_BITS_DEF,
   localparam int DW         = COORD_BITS + 1,
   localparam int SIDE_W     = SIDE_DN + 3 * DW
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [COORD_BITS-1:0] cur_north,
   input  wire logic signed [COORD_BITS-1:0] cur_east,
   input  wire logic signed [COORD_BITS-1:0] cur_elev,
   input  wire logic signed [COORD_BITS-1:0] target_north,
   input  wire logic signed [COORD_BITS-1:0] target_east,
   input  wire logic signed [COORD_BITS-1:0] target_elev,
   input  wire logic        [TOL_W-1:0]      reach_tolerance,
   input  wire logic                         target_set,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [CORDIC_W-1:0]        out_x,
   output logic signed [CORDIC_W-1:0]        out_y,
   output logic        [SIDE_W-1:0]          out_side
);

   localparam int GUARD_BITS = SCALE_BITS - COORD_BITS;
   localparam int CW         = (DW > TOL_W) ? DW : TOL_W;
   localparam int SQ_W       = 2 * TOL_W;

   // ---------------- stage A: differences and magnitudes ----------------
   logic                 a_valid_ff, a_ready;
   logic signed [DW-1:0] dn_in, de_in, dz_in, ndn_in, nde_in;
   logic signed [DW-1:0] dn_a_ff, de_a_ff, dz_a_ff;
   logic        [DW-1:0] ax_in, ay_in, ax_ff, ay_ff;
   logic                 zero_in, zero_a_ff, tset_a_ff;

   // both directions in parallel, pick by sign for the magnitude
   assign dn_in  = $signed({target_north[COORD_BITS-1], target_north})
                 - $signed({cur_north[COORD_BITS-1], cur_north});
   assign ndn_in = $signed({cur_north[COORD_BITS-1], cur_north})
                 - $signed({target_north[COORD_BITS-1], target_north});
   assign de_in  = $signed({target_east[COORD_BITS-1], target_east})
                 - $signed({cur_east[COORD_BITS-1], cur_east});
   assign nde_in = $signed({cur_east[COORD_BITS-1], cur_east})
                 - $signed({target_east[COORD_BITS-1], target_east});
   assign dz_in  = $signed({target_elev[COORD_BITS-1], target_elev})
                 - $signed({cur_elev[COORD_BITS-1], cur_elev});
   assign ax_in  = dn_in[DW-1] ? $unsigned(ndn_in) : $unsigned(dn_in);
   assign ay_in  = de_in[DW-1] ? $unsigned(nde_in) : $unsigned(de_in);
   assign zero_in = (target_north == cur_north) && (target_east == cur_east);

   // ---------------- stage B: squares and seed ----------------
   logic                       b_valid_ff, b_ready;
   logic        [CW-1:0]       ax_e, ay_e, tol_e;
   logic        [TOL_W-1:0]    ax32, ay32;
   logic        [SQ_W-1:0]     axsq_in, aysq_in, tolsq_in, axsq_ff, aysq_ff, tolsq_ff;
   logic                       in_range_in, in_range_ff;
   logic signed [CORDIC_W-1:0] x_in, y_in, x_b_ff, y_b_ff;
   logic signed [DW-1:0]       dn_b_ff, de_b_ff, dz_b_ff;
   logic                       zero_b_ff, tset_b_ff;

   assign ax_e  = CW'(ax_ff);
   assign ay_e  = CW'(ay_ff);
   assign tol_e = CW'(reach_tolerance);
   // beyond the tolerance on either axis means out of reach; else both fit TOL_W
   assign in_range_in = (ax_e <= tol_e) && (ay_e <= tol_e);
   assign ax32     = ax_e[TOL_W-1:0];
   assign ay32     = ay_e[TOL_W-1:0];
   assign axsq_in  = ax32 * ax32;
   assign aysq_in  = ay32 * ay32;
   assign tolsq_in = reach_tolerance * reach_tolerance;
   assign x_in = $signed(CORDIC_W'(ax_ff) << GUARD_BITS);
   assign y_in = $signed(CORDIC_W'(ay_ff) << GUARD_BITS);

   // ---------------- stage C: reach compare and packing ----------------
   logic                       c_valid_ff, c_ready;
   logic        [SQ_W:0]       sqsum;
   logic                       reached_in;
   logic        [SIDE_W-1:0]   side_in, side_ff;
   logic signed [CORDIC_W-1:0] x_c_ff, y_c_ff;

   assign sqsum      = {1'b0, axsq_ff} + {1'b0, aysq_ff};
   assign reached_in = in_range_ff && (sqsum <= {1'b0, tolsq_ff});

   always_comb begin
      side_in                       = '0;
      side_in[SIDE_TSET]            = tset_b_ff;
      side_in[SIDE_ZERO]            = zero_b_ff;
      side_in[SIDE_REACHED]         = reached_in;
      side_in[SIDE_DN +: DW]        = dn_b_ff;
      side_in[SIDE_DN + DW +: DW]   = de_b_ff;
      side_in[SIDE_DN + 2*DW +: DW] = dz_b_ff;
   end

   // ready ripples back from the last stage
   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         dn_a_ff   <= dn_in;
         de_a_ff   <= de_in;
         dz_a_ff   <= dz_in;
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         zero_a_ff <= zero_in;
         tset_a_ff <= target_set;
      end
      if (b_ready && a_valid_ff) begin
         axsq_ff     <= axsq_in;
         aysq_ff     <= aysq_in;
         tolsq_ff    <= tolsq_in;
         in_range_ff <= in_range_in;
         x_b_ff      <= x_in;
         y_b_ff      <= y_in;
         dn_b_ff     <= dn_a_ff;
         de_b_ff     <= de_a_ff;
         dz_b_ff     <= dz_a_ff;
         zero_b_ff   <= zero_a_ff;
         tset_b_ff   <= tset_a_ff;
      end
      if (c_ready && b_valid_ff) begin
         x_c_ff  <= x_b_ff;
         y_c_ff  <= y_b_ff;
         side_ff <= side_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_x     = x_c_ff;
   assign out_y     = y_c_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

/* design/srb_cell.sv */
// One CORDIC vectoring iteration with its own pipeline register.
`default_nettype none

module srb_cell
   import srb_pkg::*;
#(
   parameter int SHIFT  = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic signed [CORDIC_W-1:0] in_x,
   input  wire logic signed [CORDIC_W-1:0] in_y,
   input  wire logic        [ANGLE_W-1:0]  in_z,
   input  wire logic        [SIDE_W-1:0]   in_side,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic signed [CORDIC_W-1:0]      out_x,
   output logic signed [CORDIC_W-1:0]      out_y,
   output logic        [ANGLE_W-1:0]       out_z,
   output logic        [SIDE_W-1:0]        out_side
);

   logic                       valid_ff;
   logic signed [CORDIC_W-1:0] dx, dy, x_in, y_in, x_ff, y_ff;
   logic        [ANGLE_W-1:0]  z_in, z_ff;
   logic        [SIDE_W-1:0]   side_ff;

   // shifts round toward minus infinity
   assign dx = in_y >>> SHIFT;
   assign dy = in_x >>> SHIFT;

   // rotate toward the x axis; angle accumulates modulo one turn
   always_comb begin
      if (!in_y[CORDIC_W-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN_BAM[SHIFT];
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN_BAM[SHIFT];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

/* design/srb_back.sv */
// Back stages: gain removal, quadrant fold, bearing scaling and result register.
`default_nettype none

module srb_back
   import srb_pkg::*;
#(
   parameter  int COORD_BITS = COORD_BITS_DEF,
   localparam int DW         = COORD_BITS + 1,
   localparam int SIDE_W     = SIDE_DN + 3 * DW
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic signed [CORDIC_W-1:0] in_x,
   input  wire logic        [ANGLE_W-1:0]  in_z,
   input  wire logic        [SIDE_W-1:0]   in_side,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_result_valid,
   output logic signed [DW-1:0]            rsp_delta_north,
   output logic signed [DW-1:0]            rsp_delta_east,
   output logic signed [DW-1:0]            rsp_delta_elev,
   output logic        [DW-1:0]            rsp_horiz_distance,
   output logic        [BEARING_W-1:0]     rsp_bearing,
   output logic                            rsp_reached
);

   localparam int GUARD_BITS  = SCALE_BITS - COORD_BITS;
   localparam int HALF_W      = CORDIC_W / 2;
   localparam int PP_W        = HALF_W + TOL_W;
   localparam int PROD_W      = CORDIC_W + TOL_W;
   localparam int ROUND_SHIFT = 31 + GUARD_BITS;
   localparam int DIST_SHIFT  = 32 + GUARD_BITS;
   localparam int BPROD_W     = ANGLE_W + BEARING_W;
   localparam logic [ANGLE_W-1:0] ANG_HALF = {1'b1, {(ANGLE_W-1){1'b0}}};

   // ---------------- P1: partial products and quadrant fold ----------------
   logic                p1_valid_ff, p1_ready;
   logic [PP_W-1:0]     pl_in, ph_in, pl_ff, ph_ff;
   logic [ANGLE_W-1:0]  ang_in, ang_ff;
   logic [SIDE_W-1:0]   side1_ff;
   logic                dn_neg, de_neg;

   assign pl_in  = in_x[HALF_W-1:0] * INV_GAIN;
   assign ph_in  = in_x[CORDIC_W-1:HALF_W] * INV_GAIN;
   assign dn_neg = in_side[SIDE_DN + DW - 1];
   assign de_neg = in_side[SIDE_DN + 2*DW - 1];

   // rotator angle is from north toward east in the first quadrant
   always_comb begin
      if (!dn_neg && !de_neg) begin
         ang_in = in_z;
      end else if (dn_neg && !de_neg) begin
         ang_in = ANG_HALF - in_z;
      end else if (dn_neg) begin
         ang_in = ANG_HALF + in_z;
      end else begin
         ang_in = '0 - in_z;
      end
   end

   // ---------------- P2: distance rounding, bearing product ----------------
   logic                p2_valid_ff, p2_ready;
   logic [PROD_W-1:0]   prod, dist_full;
   logic [DW-1:0]       dist_in, dist_ff;
   logic [BPROD_W-1:0]  bprod_in, bprod_ff;
   logic [SIDE_W-1:0]   side2_ff;

   assign prod      = {ph_ff, {HALF_W{1'b0}}} + PROD_W'(pl_ff)
                    + (PROD_W'(1) << ROUND_SHIFT);
   assign dist_full = prod >> DIST_SHIFT;
   assign dist_in   = (dist_full > PROD_W'({DW{1'b1}})) ? {DW{1'b1}} : dist_full[DW-1:0];
   assign bprod_in  = ang_ff * TURN_UNITS;

   // ---------------- P3: bearing rounding, wrap and result ----------------
   logic                 p3_valid_ff, p3_ready;
   logic [BPROD_W-1:0]   bsum;
   logic [BEARING_W-1:0] braw, bwrap;
   logic                 tset, zero;
   logic                 result_valid_in, result_valid_ff, reached_in, reached_ff;
   logic signed [DW-1:0] dn_in, de_in, dz_in, dn_ff, de_ff, dz_ff;
   logic [DW-1:0]        hd_in, hd_ff;
   logic [BEARING_W-1:0] bearing_in, bearing_ff;

   assign bsum  = bprod_ff + (BPROD_W'(1) << (ANGLE_W - 1));
   assign braw  = bsum[BPROD_W-1:ANGLE_W];
   assign bwrap = (braw >= TURN_UNITS) ? braw - TURN_UNITS : braw;
   assign tset  = side2_ff[SIDE_TSET];
   assign zero  = side2_ff[SIDE_ZERO];

   // no target: everything zero; zero offset: no distance, no bearing
   always_comb begin
      result_valid_in = tset;
      reached_in      = tset && side2_ff[SIDE_REACHED];
      dn_in           = tset ? $signed(side2_ff[SIDE_DN +: DW]) : '0;
      de_in           = tset ? $signed(side2_ff[SIDE_DN + DW +: DW]) : '0;
      dz_in           = tset ? $signed(side2_ff[SIDE_DN + 2*DW +: DW]) : '0;
      hd_in           = (tset && !zero) ? dist_ff : '0;
      bearing_in      = (tset && !zero) ? bwrap : '0;
   end

   // handshake chain
   assign p3_ready = !p3_valid_ff || rsp_ready;
   assign p2_ready = !p2_valid_ff || p3_ready;
   assign p1_ready = !p1_valid_ff || p2_ready;
   assign in_ready = p1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         if (p1_ready) p1_valid_ff <= in_valid;
         if (p2_ready) p2_valid_ff <= p1_valid_ff;
         if (p3_ready) p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_ready && in_valid) begin
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         ang_ff   <= ang_in;
         side1_ff <= in_side;
      end
      if (p2_ready && p1_valid_ff) begin
         dist_ff  <= dist_in;
         bprod_ff <= bprod_in;
         side2_ff <= side1_ff;
      end
      if (p3_ready && p2_valid_ff) begin
         result_valid_ff <= result_valid_in;
         reached_ff      <= reached_in;
         dn_ff           <= dn_in;
         de_ff           <= de_in;
         dz_ff           <= dz_in;
         hd_ff           <= hd_in;
         bearing_ff      <= bearing_in;
      end
   end

   assign rsp_valid          = p3_valid_ff;
   assign rsp_result_valid   = result_valid_ff;
   assign rsp_delta_north    = dn_ff;
   assign rsp_delta_east     = de_ff;
   assign rsp_delta_elev     = dz_ff;
   assign rsp_horiz_distance = hd_ff;
   assign rsp_bearing        = bearing_ff;
   assign rsp_reached        = reached_ff;

endmodule

`default_nettype wire

/* design/stakeout_range_bearing_top.sv */
// Top level of the stakeout range and bearing pipeline.
//
// Each position fix on the req_ channel yields one transaction on the rsp_
// channel: target-minus-current deltas, horizontal distance (rounded mm),
// bearing in 1/65536 degree clockwise from north, and a reached flag decided
// exactly on squared distance. The datapath is a fully pipelined chain: three
// front stages (deltas, squares, reach compare), one cell per CORDIC
// iteration, and three back stages (gain removal, bearing scaling, result
// register). One transaction is accepted every cycle while rsp_ready keeps
// up; a stalled response stalls only the stages behind it, so empty stages
// still fill. req_ready depends combinationally on rsp_ready through the
// stage chain. Write the csr_ registers only while nothing is in flight;
// with target_set clear every response carries result_valid 0 and all
// fields zero.
`default_nettype none

module stakeout_range_bearing_top
   import srb_pkg::*;
#(
   parameter  int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter  int COORD_BITS    = COORD_BITS_DEF,
   localparam int DW            = COORD_BITS + 1,
   localparam int CSR_W         = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // position fixes
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_cur_north,
   input  wire logic signed [COORD_BITS-1:0] req_cur_east,
   input  wire logic signed [COORD_BITS-1:0] req_cur_elev,
   // results
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_result_valid,
   output logic signed [DW-1:0]              rsp_delta_north,
   output logic signed [DW-1:0]              rsp_delta_east,
   output logic signed [DW-1:0]              rsp_delta_elev,
   output logic        [DW-1:0]              rsp_horiz_distance,
   output logic        [BEARING_W-1:0]       rsp_bearing,
   output logic                              rsp_reached,
   // configuration
   input  wire logic                         csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_W-1:0]             csr_wr_data
);

   localparam int SIDE_W = SIDE_DN + 3 * DW;

   // ---------------- configuration registers ----------------
   logic signed [COORD_BITS-1:0] target_north_ff, target_east_ff, target_elev_ff;
   logic        [TOL_W-1:0]      reach_tolerance_ff;
   logic                         target_set_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_north_ff    <= '0;
         target_east_ff     <= '0;
         target_elev_ff     <= '0;
         reach_tolerance_ff <= '0;
         target_set_ff      <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_NORTH:    target_north_ff    <= $signed(csr_wr_data[COORD_BITS-1:0]);
            CSR_TARGET_EAST:     target_east_ff     <= $signed(csr_wr_data[COORD_BITS-1:0]);
            CSR_TARGET_ELEV:     target_elev_ff     <= $signed(csr_wr_data[COORD_BITS-1:0]);
            CSR_REACH_TOLERANCE: reach_tolerance_ff <= csr_wr_data[TOL_W-1:0];
            CSR_TARGET_SET:      target_set_ff      <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- stage chain wiring ----------------
   logic                       valid_chain [CORDIC_STAGES+1];
   logic                       ready_chain [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] x_chain     [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] y_chain     [CORDIC_STAGES+1];
   logic        [ANGLE_W-1:0]  z_chain     [CORDIC_STAGES+1];
   logic        [SIDE_W-1:0]   side_chain  [CORDIC_STAGES+1];

   assign z_chain[0] = '0;

   srb_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .cur_north       (req_cur_north),
      .cur_east        (req_cur_east),
      .cur_elev        (req_cur_elev),
      .target_north    (target_north_ff),
      .target_east     (target_east_ff),
      .target_elev     (target_elev_ff),
      .reach_tolerance (reach_tolerance_ff),
      .target_set      (target_set_ff),
      .out_valid       (valid_chain[0]),
      .out_ready       (ready_chain[0]),
      .out_x           (x_chain[0]),
      .out_y           (y_chain[0]),
      .out_side        (side_chain[0])
   );

   // one cell per CORDIC iteration
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      srb_cell #(
         .SHIFT  (i),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_x      (x_chain[i]),
         .in_y      (y_chain[i]),
         .in_z      (z_chain[i]),
         .in_side   (side_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_x     (x_chain[i+1]),
         .out_y     (y_chain[i+1]),
         .out_z     (z_chain[i+1]),
         .out_side  (side_chain[i+1])
      );
   end

   srb_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (valid_chain[CORDIC_STAGES]),
      .in_ready           (ready_chain[CORDIC_STAGES]),
      .in_x               (x_chain[CORDIC_STAGES]),
      .in_z               (z_chain[CORDIC_STAGES]),
      .in_side            (side_chain[CORDIC_STAGES]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_valid   (rsp_result_valid),
      .rsp_delta_north    (rsp_delta_north),
      .rsp_delta_east     (rsp_delta_east),
      .rsp_delta_elev     (rsp_delta_elev),
      .rsp_horiz_distance (rsp_horiz_distance),
      .rsp_bearing        (rsp_bearing),
      .rsp_reached        (rsp_reached)
   );

   // ---------------- assertions ----------------

   // an empty or draining output register lets the whole chain move
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while output stage can move");

   // no target: every field of the result is zero
   a_no_target_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_valid) |->
         (rsp_delta_north == '0 && rsp_delta_east == '0 && rsp_delta_elev == '0 &&
          rsp_horiz_distance == '0 && rsp_bearing == '0 && !rsp_reached))
      else $error("nonzero field without a target");

   // zero horizontal offset: no distance, no bearing, always reached
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_valid && rsp_delta_north == '0 && rsp_delta_east == '0) |->
         (rsp_horiz_distance == '0 && rsp_bearing == '0 && rsp_reached))
      else $error("zero offset gave distance or bearing");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
